// ===== hdl/nucleotide_range_min_query_core_defines.svh =====
// Assertion macros shared by the nucleotide range minimum query block.
`ifndef NUCLEOTIDE_RANGE_MIN_QUERY_CORE_DEFINES_SVH
`define NUCLEOTIDE_RANGE_MIN_QUERY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define NRMQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nrmq assertion failed");
`define NRMQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("nrmq assertion failed");
`else
`define NRMQ_ASSERT(label, clk, rst, prop)
`define NRMQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hdl/nrmq_pkg.sv =====
// Types and constants of the nucleotide range minimum query block.
package nrmq_pkg;

   localparam int MAX_BASES  = 4096;
   localparam int LEN_W      = $clog2(MAX_BASES + 1);
   localparam int POS_W      = $clog2(MAX_BASES);
   localparam int CNT_W      = LEN_W;
   localparam int FUNC_W     = 2;
   localparam int BASE_W     = 2;
   localparam int RANGE_W    = 12;
   localparam int IMPACT_W   = 3;
   localparam int REQ_DATA_W = ((BASE_W + 2 * RANGE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((IMPACT_W + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   localparam logic [BASE_W-1:0] BASE_A = 2'd0;
   localparam logic [BASE_W-1:0] BASE_C = 2'd1;
   localparam logic [BASE_W-1:0] BASE_G = 2'd2;

   localparam logic [IMPACT_W-1:0] IMPACT_A = 3'd1;
   localparam logic [IMPACT_W-1:0] IMPACT_C = 3'd2;
   localparam logic [IMPACT_W-1:0] IMPACT_G = 3'd3;
   localparam logic [IMPACT_W-1:0] IMPACT_T = 3'd4;

   typedef struct packed {
      logic [CNT_W-1:0] a;
      logic [CNT_W-1:0] c;
      logic [CNT_W-1:0] g;
   } counts_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      counts_type       data;
   } store_wr_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] lo_addr;
      logic [POS_W-1:0] hi_addr;
   } store_rd_type;

endpackage

// ===== hdl/nucleotide_range_min_query_core.sv =====
// Top level of the nucleotide range minimum query block.
//
// Request beats carry a command in req_tuser: append one base, clear the
// sequence, or query an inclusive position range. Appends and clears give
// no response beat; a query gives exactly one, with the smallest impact
// factor in the range (A=1 C=2 G=3 T=4) in rsp_tdata and an error flag in
// rsp_tuser for a range past the loaded length or with start after end.
// An append to a full store of 4096 bases is dropped.
// Throughput is one request beat per cycle unless a stalled response
// holds req_tready low. A query answer passes the registered reads of the
// prefix count memory at both range ends, then the compare into the
// output register. Appends keep the running counts in a register, so they
// write the memory without reading it.
// A stalled response holds in the output register; one more query may wait
// in the read stage, after which req_tready drops until rsp_tready returns.
// Reset empties the sequence and the pipeline; memory contents are left
// as they are, and stale entries read by a query never reach its answer.
module nucleotide_range_min_query_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // base [1:0], range_start [13:2], range_end [25:14], zero above
   input  logic [nrmq_pkg::REQ_DATA_W-1:0] req_tdata,
   // func [1:0]
   input  logic [nrmq_pkg::FUNC_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // min_impact [2:0], zero above
   output logic [nrmq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // range_error [0]
   output logic                            rsp_tuser
);
   import nrmq_pkg::*;

   `include "nucleotide_range_min_query_core_defines.svh"

   logic [BASE_W-1:0]  req_base;
   logic [RANGE_W-1:0] req_first;
   logic [RANGE_W-1:0] req_last;
   logic               accept;
   logic               advance;
   logic               full;
   logic               do_append;
   logic               do_clear;
   logic               do_query;
   logic               q_err;

   logic [LEN_W-1:0]    len_ff, len_in;
   counts_type          tail_ff, tail_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_err_ff;
   logic                s1_lo_zero_ff;
   logic                out_valid_ff, out_valid_in;
   logic [IMPACT_W-1:0] out_impact_ff, out_impact_in;
   logic                out_err_ff;

   store_wr_type wr;
   store_rd_type rd;
   counts_type   rd_lo;
   counts_type   rd_hi;
   counts_type   lo_counts;

   assign req_base  = req_tdata[BASE_W-1:0];
   assign req_first = req_tdata[BASE_W +: RANGE_W];
   assign req_last  = req_tdata[BASE_W + RANGE_W +: RANGE_W];

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign full       = (len_ff == LEN_W'(MAX_BASES));

   always_comb begin
      do_append = 1'b0;
      do_clear  = 1'b0;
      do_query  = 1'b0;
      unique case (req_tuser)
         FUNC_APPEND: do_append = accept && !full;
         FUNC_CLEAR:  do_clear  = accept;
         FUNC_QUERY:  do_query  = accept;
         default: ;
      endcase
   end

   assign q_err = (LEN_W'(req_last) >= len_ff) || (req_first > req_last);

   always_comb begin
      tail_in = tail_ff;
      len_in  = len_ff;
      if (do_append) begin
         tail_in.a = tail_ff.a + CNT_W'(req_base == BASE_A);
         tail_in.c = tail_ff.c + CNT_W'(req_base == BASE_C);
         tail_in.g = tail_ff.g + CNT_W'(req_base == BASE_G);
         len_in    = len_ff + LEN_W'(1);
      end else if (do_clear) begin
         tail_in = '0;
         len_in  = '0;
      end
   end

   assign wr.en      = do_append;
   assign wr.addr    = len_ff[POS_W-1:0];
   assign wr.data    = tail_in;
   assign rd.en      = do_query;
   assign rd.lo_addr = POS_W'(req_first) - POS_W'(1);
   assign rd.hi_addr = POS_W'(req_last);

   nrmq_store u_store (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rd_lo (rd_lo),
      .rd_hi (rd_hi)
   );

   assign lo_counts    = s1_lo_zero_ff ? '0 : rd_lo;
   assign s1_valid_in  = do_query || (s1_valid_ff && !advance);
   assign out_valid_in = (s1_valid_ff && advance) || (out_valid_ff && !rsp_tready);

   always_comb begin
      if (s1_err_ff) begin
         out_impact_in = IMPACT_T;
      end else if (rd_hi.a != lo_counts.a) begin
         out_impact_in = IMPACT_A;
      end else if (rd_hi.c != lo_counts.c) begin
         out_impact_in = IMPACT_C;
      end else if (rd_hi.g != lo_counts.g) begin
         out_impact_in = IMPACT_G;
      end else begin
         out_impact_in = IMPACT_T;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         tail_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         tail_ff      <= tail_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_query) begin
         s1_err_ff     <= q_err;
         s1_lo_zero_ff <= (req_first == '0);
      end
      if (s1_valid_ff && advance) begin
         out_impact_ff <= out_impact_in;
         out_err_ff    <= s1_err_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_impact_ff);
   assign rsp_tuser  = out_err_ff;

   `NRMQ_ASSERT(a_len_bound, clock, reset, len_ff <= LEN_W'(MAX_BASES))
   `NRMQ_ASSERT(a_err_impact, clock, reset, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == RSP_DATA_W'(IMPACT_T)))
   `NRMQ_ASSERT(a_no_overrun, clock, reset, (s1_valid_ff && !advance) |-> !req_tready)
   `NRMQ_ASSERT(a_append_len, clock, reset, do_append |=> (len_ff == $past(len_ff) + LEN_W'(1)))
   `NRMQ_ASSERT(a_clear_len, clock, reset, do_clear |=> (len_ff == '0))

endmodule

// ===== hdl/nrmq_store.sv =====
// Prefix count memory: one write port, two registered read ports.
module nrmq_store (
   input  logic                  clock,
   input  nrmq_pkg::store_wr_type wr,
   input  nrmq_pkg::store_rd_type rd,
   output nrmq_pkg::counts_type  rd_lo,
   output nrmq_pkg::counts_type  rd_hi
);
   import nrmq_pkg::*;

   // entry i holds the counts over positions 0..i
   counts_type mem [MAX_BASES];
   counts_type rd_lo_ff;
   counts_type rd_hi_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_lo_ff <= mem[rd.lo_addr];
         rd_hi_ff <= mem[rd.hi_addr];
      end
   end

   assign rd_lo = rd_lo_ff;
   assign rd_hi = rd_hi_ff;

endmodule
